// ===== hw/rtl/rmc_pkg.sv =====
// Shared constants, state encoding and config struct for the reachability matrix core.
// No dependencies; every other file but rmc_ram imports this package.
package rmc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int ROW_BITS         = 16;
  localparam int VC_W             = 5;
  localparam int VX_W             = 4;
  localparam int MODE_W           = 2;

  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_ADD_RESP,
    ST_INIT,
    ST_INIT_DRAIN,
    ST_KRD,
    ST_KCAP,
    ST_SWEEP,
    ST_SWEEP_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // effective vertex count and the matching column mask
  typedef struct packed {
    logic [VC_W-1:0]     count;
    logic [ROW_BITS-1:0] colmask;
  } rmc_cfg_t;

endpackage

// ===== hw/rtl/rmc_if.sv =====
// Valid/ready channel interfaces: input item, result item, config write.
// Depends on rmc_pkg for field widths.
interface rmc_in_if;
  import rmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VX_W-1:0]   source_vertex;
  logic [VX_W-1:0]   dest_vertex;
  modport source(output valid, mode, source_vertex, dest_vertex, input ready);
  modport sink(input valid, mode, source_vertex, dest_vertex, output ready);
endinterface

interface rmc_out_if;
  import rmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [VX_W-1:0]     row_index;
  logic [ROW_BITS-1:0] reach_bits;
  logic                status;
  logic                last_row;
  modport source(output valid, row_index, reach_bits, status, last_row, input ready);
  modport sink(input valid, row_index, reach_bits, status, last_row, output ready);
endinterface

interface rmc_cfg_if;
  import rmc_pkg::*;
  logic            valid;
  logic            ready;
  logic [VC_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/reachability_matrix_core.sv =====
// Reachability matrix core: clear empties the adjacency store and gives no result. Add edge:
// one result item. Compute: an init pass seeds each row from adjacency, then n Warshall
// passes of n rows each run through the single read port of the reach memory, then each
// result row is read and then loaded, held while the output stalls. One item at a time.
// Reset (rst_n low, synchronous): adjacency cleared via valid bits, vertex_count = 16.
// Depends on rmc_pkg, rmc_if, rmc_ram, rmc_engine.
module reachability_matrix_core #(
  parameter int MAX_VERTICES = rmc_pkg::MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmc_in_if.sink    in_ch,
  rmc_out_if.source out_ch,
  rmc_cfg_if.sink   cfg_ch
);
  import rmc_pkg::*;

  localparam int ROWS = (MAX_VERTICES < ROW_BITS) ? MAX_VERTICES : ROW_BITS;
  localparam logic [VC_W-1:0] CAP = VC_W'(ROWS);

  logic [VC_W-1:0] vc_r, vc_nxt;
  rmc_cfg_t cfg;

  assign cfg_ch.ready = 1'b1;
  assign vc_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else begin
      vc_r <= vc_nxt;
    end
  end

  // zero counts as one vertex, large counts saturate at the row capacity
  always_comb begin
    if (vc_r == '0) begin
      cfg.count = VC_W'(1);
    end else if (vc_r > CAP) begin
      cfg.count = CAP;
    end else begin
      cfg.count = vc_r;
    end
    for (int j = 0; j < ROW_BITS; j++) begin
      cfg.colmask[j] = (VC_W'(j) < cfg.count);
    end
  end

  rmc_engine #(.ROWS(ROWS)) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

endmodule

// ===== hw/rtl/rmc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rmc_engine.sv =====
// Sequencer and datapath: adjacency RAM with valid bits, reach RAM, Warshall
// row sweeps and the result register. Depends on rmc_pkg, rmc_if, rmc_ram.
module rmc_engine #(
  parameter int ROWS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rmc_in_if.sink            in_ch,
  rmc_out_if.source         out_ch,
  input  rmc_pkg::rmc_cfg_t cfg
);
  import rmc_pkg::*;

  localparam int AW = $clog2(ROWS);

  state_t state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt, k_r, k_nxt, src_r, src_nxt, wb_addr_r;
  logic [VX_W-1:0] dst_r, dst_nxt;
  logic bad_r, bad_nxt;
  logic [ROWS-1:0] adj_vld_r, adj_vld_nxt;
  logic wb_v_r, wb_v_nxt, wb_init_r, wb_init_nxt;
  logic [ROW_BITS-1:0] rowk_r, rowk_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [VX_W-1:0] out_row_r, out_row_nxt;
  logic [ROW_BITS-1:0] out_bits_r, out_bits_nxt;
  logic out_stat_r, out_stat_nxt, out_last_r, out_last_nxt;
  logic out_load, out_free;

  logic accept, last_i, last_k, src_bad;
  logic adj_we, adj_re, reach_we, reach_re;
  logic [AW-1:0] adj_waddr, adj_raddr, reach_raddr;
  logic [ROW_BITS-1:0] adj_wdata, adj_rdata, reach_wdata, reach_rdata, k_onehot;
  logic [ROW_BITS-1:0] adj_row_init;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_i      = (VC_W'(i_r) == cfg.count - VC_W'(1));
  assign last_k      = (VC_W'(k_r) == cfg.count - VC_W'(1));
  assign src_bad     = (VC_W'(in_ch.source_vertex) >= cfg.count) ||
                       (VC_W'(in_ch.dest_vertex) >= cfg.count);
  assign k_onehot    = ROW_BITS'(1) << k_r;

  rmc_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  rmc_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (wb_addr_r),
    .wdata (reach_wdata),
    .re    (reach_re),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  // Write-back in the cycle after each row read: seed from adjacency, or
  // Warshall update R[i] |= R[k] when R[i] reaches k.
  assign adj_row_init = adj_vld_r[wb_addr_r] ? adj_rdata : '0;
  assign reach_we     = wb_v_r;
  assign reach_wdata  = wb_init_r ? (adj_row_init & cfg.colmask) :
                        (reach_rdata | ((|(reach_rdata & k_onehot)) ? rowk_r : '0));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_ADD:   state_nxt = src_bad ? ST_ADD_RESP : ST_ADD_WR;
            MODE_CLOSE: state_nxt = ST_INIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR:      state_nxt = ST_ADD_RESP;
      ST_ADD_RESP:    if (out_free) state_nxt = ST_IDLE;
      ST_INIT:        if (last_i) state_nxt = ST_INIT_DRAIN;
      ST_INIT_DRAIN:  state_nxt = ST_KRD;
      ST_KRD:         state_nxt = ST_KCAP;
      ST_KCAP:        state_nxt = ST_SWEEP;
      ST_SWEEP:       if (last_i) state_nxt = ST_SWEEP_DRAIN;
      ST_SWEEP_DRAIN: state_nxt = last_k ? ST_EMIT_RD : ST_KRD;
      ST_EMIT_RD:     state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:     if (out_free) state_nxt = last_i ? ST_IDLE : ST_EMIT_RD;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    i_nxt        = i_r;
    k_nxt        = k_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    bad_nxt      = bad_r;
    adj_vld_nxt  = adj_vld_r;
    wb_v_nxt     = 1'b0;
    wb_init_nxt  = wb_init_r;
    rowk_nxt     = rowk_r;
    adj_we       = 1'b0;
    adj_waddr    = src_r;
    adj_wdata    = (adj_vld_r[src_r] ? adj_rdata : '0) | (ROW_BITS'(1) << dst_r);
    adj_re       = 1'b0;
    adj_raddr    = i_r;
    reach_re     = 1'b0;
    reach_raddr  = i_r;
    out_load     = 1'b0;
    out_row_nxt  = '0;
    out_bits_nxt = '0;
    out_stat_nxt = STAT_OK;
    out_last_nxt = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          i_nxt   = '0;
          k_nxt   = '0;
          src_nxt = in_ch.source_vertex[AW-1:0];
          dst_nxt = in_ch.dest_vertex;
          bad_nxt = src_bad;
          case (in_ch.mode)
            MODE_CLEAR: adj_vld_nxt = '0;
            MODE_ADD: begin
              adj_re    = !src_bad;
              adj_raddr = in_ch.source_vertex[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        adj_we      = 1'b1;
        adj_vld_nxt = adj_vld_r | (ROWS'(1) << src_r);
      end
      ST_ADD_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_stat_nxt = bad_r ? STAT_BAD : STAT_OK;
        end
      end
      ST_INIT: begin
        adj_re      = 1'b1;
        wb_v_nxt    = 1'b1;
        wb_init_nxt = 1'b1;
        i_nxt       = last_i ? '0 : i_r + AW'(1);
      end
      ST_KRD: begin
        reach_re    = 1'b1;
        reach_raddr = k_r;
      end
      ST_KCAP: begin
        rowk_nxt = reach_rdata;
        i_nxt    = '0;
      end
      ST_SWEEP: begin
        reach_re    = 1'b1;
        wb_v_nxt    = 1'b1;
        wb_init_nxt = 1'b0;
        i_nxt       = last_i ? '0 : i_r + AW'(1);
      end
      ST_SWEEP_DRAIN: begin
        i_nxt = '0;
        if (!last_k) k_nxt = k_r + AW'(1);
      end
      ST_EMIT_RD: reach_re = 1'b1;
      ST_EMIT_LD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_row_nxt  = VX_W'(i_r);
          out_bits_nxt = reach_rdata;
          out_last_nxt = last_i;
          i_nxt        = last_i ? '0 : i_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      adj_vld_r   <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      adj_vld_r   <= adj_vld_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    bad_r     <= bad_nxt;
    wb_init_r <= wb_init_nxt;
    wb_addr_r <= i_r;
    rowk_r    <= rowk_nxt;
    if (out_load) begin
      out_row_r  <= out_row_nxt;
      out_bits_r <= out_bits_nxt;
      out_stat_r <= out_stat_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_index  = out_row_r;
  assign out_ch.reach_bits = out_bits_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.last_row   = out_last_r;

`ifndef SYNTH
  a_adj_wr_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    adj_we |-> state_r == ST_ADD_WR)
    else $error("adjacency write outside add edge");

  a_reach_wr_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    reach_we |-> (state_r == ST_INIT || state_r == ST_INIT_DRAIN ||
                  state_r == ST_SWEEP || state_r == ST_SWEEP_DRAIN))
    else $error("reach write-back outside compute");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT || state_r == ST_SWEEP || state_r == ST_EMIT_RD)
      |-> VC_W'(i_r) < cfg.count)
    else $error("row counter past vertex count");

  a_idle_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !wb_v_r)
    else $error("write-back pending while accepting an item");

  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt && state_r == ST_EMIT_LD) |=> state_r == ST_IDLE)
    else $error("last row emitted but sequencer not idle");
`endif

endmodule

// ===== verif/rmc_closure_checker.sv =====
`timescale 1ns / 100ps
// Checker for the reachability matrix core: watches the input, result and config
// channels, predicts each result row and compares it field by field.
// Depends on rmc_pkg and the channel interfaces in rmc_if.
module rmc_closure_checker #(
  parameter int MAX_VERTICES = rmc_pkg::MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rmc_in_if    in_ch,
  rmc_out_if   out_ch,
  rmc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import rmc_pkg::*;

  typedef struct packed {
    logic [VX_W-1:0]     row_index;
    logic [ROW_BITS-1:0] reach_bits;
    logic                status;
    logic                last_row;
  } row_item_t;

  localparam int VERTEX_CAP = (MAX_VERTICES < ROW_BITS) ? MAX_VERTICES : ROW_BITS;

  logic [ROW_BITS-1:0] adj_rows [ROW_BITS];
  logic [VC_W-1:0]     vertex_count;
  row_item_t           expected_rows [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int active_vertices();
    int v;
    v = vertex_count;
    if (v < 1) v = 1;
    if (v > VERTEX_CAP) v = VERTEX_CAP;
    return v;
  endfunction

  // Warshall over the active vertices; gives the same set as OR of A^1..A^n
  task automatic predict_closure();
    int n;
    logic [ROW_BITS-1:0] colmask;
    logic [ROW_BITS-1:0] reach [ROW_BITS];
    row_item_t r;
    n = active_vertices();
    colmask = '0;
    for (int i = 0; i < n; i++) colmask[i] = 1'b1;
    for (int i = 0; i < ROW_BITS; i++) reach[i] = (i < n) ? (adj_rows[i] & colmask) : '0;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        if (reach[i][k]) reach[i] |= reach[k];
    for (int i = 0; i < n; i++) begin
      r.row_index  = VX_W'(i);
      r.reach_bits = reach[i];
      r.status     = STAT_OK;
      r.last_row   = (i == n - 1);
      expected_rows.push_back(r);
    end
  endtask

  task automatic predict_item(input logic [MODE_W-1:0] mode, input logic [VX_W-1:0] src,
                              input logic [VX_W-1:0] dst);
    int n;
    row_item_t r;
    n = active_vertices();
    case (mode)
      MODE_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      MODE_ADD: begin
        r = '0;
        r.last_row = 1'b1;
        // out-of-range vertex: flagged, store untouched
        if (src >= n || dst >= n) begin
          r.status = STAT_BAD;
        end else begin
          adj_rows[src][dst] = 1'b1;
          r.status = STAT_OK;
        end
        expected_rows.push_back(r);
      end
      MODE_CLOSE: predict_closure();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: result mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_row(input row_item_t got);
    row_item_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("row %0d arrived with no item expected", got.row_index));
    end else begin
      want = expected_rows.pop_front();
      if (got.row_index !== want.row_index)
        report_mismatch($sformatf("row_index %0d, expected %0d", got.row_index,
                                  want.row_index));
      if (got.reach_bits !== want.reach_bits)
        report_mismatch($sformatf("row %0d reach_bits %h, expected %h", want.row_index,
                                  got.reach_bits, want.reach_bits));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
      if (got.last_row !== want.last_row)
        report_mismatch($sformatf("row %0d last_row %b, expected %b", want.row_index,
                                  got.last_row, want.last_row));
    end
  endtask

  always @(posedge clk) begin
    row_item_t got;
    if (!rst_n) begin
      expected_rows.delete();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vertex_count = VC_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) vertex_count = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.mode, in_ch.source_vertex, in_ch.dest_vertex);
      if (out_ch.valid && out_ch.ready) begin
        got.row_index  = out_ch.row_index;
        got.reach_bits = out_ch.reach_bits;
        got.status     = out_ch.status;
        got.last_row   = out_ch.last_row;
        check_row(got);
      end
    end
    pending = expected_rows.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the reachability matrix core testbench: clock, reset, stimulus and verdict.
// Depends on rmc_pkg, rmc_if, the core itself and rmc_closure_checker.
module testbench;
  import rmc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 400;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int N_PHASES        = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;

  rmc_in_if  in_ch();
  rmc_out_if out_ch();
  rmc_cfg_if cfg_ch();

  reachability_matrix_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  rmc_closure_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VX_W-1:0] src,
                           input logic [VX_W-1:0] dst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.source_vertex <= src;
    in_ch.dest_vertex   <= dst;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // drain everything, let a trailing clear finish, then write the register
  task automatic set_vertex_count(input int value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= VC_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int vc_plan [N_PHASES] = '{1, 16, 0, 3, 31, 5, 16, 9, 17, 2};
    int n;
    int phase_items;
    int adds;
    logic [MODE_W-1:0] mode;

    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_CLEAR;
    in_ch.source_vertex = '0;
    in_ch.dest_vertex   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: full-size graph with a cycle, a self loop and high vertices
    send_item(MODE_CLEAR, 4'd0, 4'd0);
    send_item(MODE_ADD, 4'd0, 4'd1);
    send_item(MODE_ADD, 4'd1, 4'd2);
    send_item(MODE_ADD, 4'd2, 4'd0);
    send_item(MODE_ADD, 4'd3, 4'd14);
    send_item(MODE_ADD, 4'd14, 4'd0);
    send_item(MODE_ADD, 4'd15, 4'd15);
    send_item(MODE_CLOSE, 4'd15, 4'd15);
    send_item(MODE_UNUSED, 4'd15, 4'd15);
    // shrink: stored edges at high vertices must drop out of the closure
    set_vertex_count(4);
    send_item(MODE_CLOSE, 4'd0, 4'd0);
    send_item(MODE_ADD, 4'd4, 4'd0);
    send_item(MODE_ADD, 4'd0, 4'd15);
    send_item(MODE_ADD, 4'd3, 4'd3);
    send_item(MODE_CLOSE, 4'd0, 4'd0);
    send_item(MODE_CLEAR, 4'd15, 4'd15);
    send_item(MODE_CLOSE, 4'd0, 4'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      set_vertex_count(vc_plan[p]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 50; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 50; end
        default: begin in_idle_pct = 6; out_stall_pct = 6; end
      endcase
      n = vc_plan[p];
      if (n < 1) n = 1;
      if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          // well-formed: optional clear, a batch of edges, then a compute
          if ($urandom_range(1)) begin
            send_item(MODE_CLEAR, VX_W'($urandom_range(15)), VX_W'($urandom_range(15)));
            phase_items++;
          end
          adds = $urandom_range(2 * n, 1);
          repeat (adds) begin
            if ($urandom_range(9) == 0)
              send_item(MODE_ADD, VX_W'($urandom_range(15)), VX_W'($urandom_range(15)));
            else
              send_item(MODE_ADD, VX_W'($urandom_range(n - 1)), VX_W'($urandom_range(n - 1)));
            phase_items++;
          end
          send_item(MODE_CLOSE, VX_W'($urandom_range(15)), VX_W'($urandom_range(15)));
          phase_items++;
        end else begin
          mode = MODE_W'($urandom_range(3));
          send_item(mode, VX_W'($urandom_range(15)), VX_W'($urandom_range(15)));
          if (mode != MODE_UNUSED) phase_items++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
